// ===== rtl/gdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdb_pkg
// Shared constants, request codes and helpers for the graph traversal engine.
// ----------------------------------------------------------------------------
package gdb_pkg;

	// default node count bound
	localparam int NODES_DEF = 256;

	// request function codes
	localparam logic [1:0] F_CLEAR = 2'd0;
	localparam logic [1:0] F_ADD   = 2'd1;
	localparam logic [1:0] F_START = 2'd2;
	localparam logic [1:0] F_FETCH = 2'd3;

	// register index, taken from paddr bit 2
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_START = 1'b1;

	// configuration handed from the register block to the engine
	typedef struct packed {
		logic       mode;
		logic [7:0] start;
	} gdb_cfg_t;

	// position of the lowest set bit of a word, zero when empty
	function automatic logic [5:0] low_bit(input logic [63:0] v);
		logic [5:0] r;
		r = 6'd0;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) r = 6'(i);
		end
		return r;
	endfunction

endpackage

// ===== rtl/gdb_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdb request and result channels
// Valid/ready channels carrying traversal requests and their results.
// ----------------------------------------------------------------------------
interface gdb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] edge_source;
	logic [7:0] edge_target;

	modport source (output valid, func, edge_source, edge_target, input ready);
	modport sink   (input valid, func, edge_source, edge_target, output ready);
endinterface

interface gdb_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] node;
	logic       node_valid;
	logic       done_res;

	modport source (output valid, node, node_valid, done_res, input ready);
	modport sink   (input valid, node, node_valid, done_res, output ready);
endinterface

// ===== rtl/gdb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gdb_ram #(
	parameter int W  = 64,
	parameter int D  = 4,
	parameter int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/gdb_apb_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdb_apb_regs
// APB register block holding the traversal mode and the start node.
// ----------------------------------------------------------------------------
module gdb_apb_regs
	import gdb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output gdb_cfg_t    cfg
);

	logic       mode_q;
	logic [7:0] start_q;
	logic       wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			start_q <= 8'd1;
		end else if (wr) begin
			if (paddr[2] == REG_MODE) mode_q <= pwdata[0];
			if (paddr[2] == REG_START) start_q <= pwdata[7:0];
		end
	end

	// read back
	assign prdata = (paddr[2] == REG_START) ? {24'd0, start_q} : {31'd0, mode_q};

	assign cfg.mode  = mode_q;
	assign cfg.start = start_q;

endmodule

// ===== rtl/graph_dfs_bfs_order_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_bfs_order_core
// Depth-first preorder or breadth-first walk over a stored directed graph.
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      func, edge_source, edge_target
//   res      out  valid/ready      node, node_valid, done_res
//   apb      in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One request at a time. Clear, start and idle fetches: result next cycle.
// Add edge: a read-modify-write of one adjacency row word.
// Fetch in a walk: reads the stack top or queue head, then scans its 64-bit
// adjacency words in turn, popping exhausted stack or queue entries; in
// depth-first order it also writes back its stack top. A fetch may end the walk.
// Clear and reset run a clearing pass over all NODES*ceil(NODES/64) rows of the
// adjacency RAM, during which no request is taken. A held result stalls intake.
// ----------------------------------------------------------------------------
module graph_dfs_bfs_order_core
	import gdb_pkg::*;
#(
	parameter int NODES = NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gdb_req_if.sink     req,
	gdb_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int WORDS = (NODES + 63) / 64;
	localparam int ROWS  = NODES * WORDS;
	localparam int NW    = $clog2(NODES);
	localparam int CW    = $clog2(NODES + 1);
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int AW    = $clog2(ROWS);
	localparam int SW    = NW + CW;

	// sequencer states
	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_AWR  = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_WEV  = 4'd4;
	localparam logic [3:0] S_SRD  = 4'd5;
	localparam logic [3:0] S_SEV  = 4'd6;
	localparam logic [3:0] S_PUSH = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	// walk phases
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ARMED = 2'd1;
	localparam logic [1:0] PH_WALK  = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	gdb_cfg_t cfg;

	logic [3:0]       st_q, st_d;
	logic [1:0]       phase_q, phase_d;
	logic             order_q, order_d;
	logic [CW-1:0]    head_q, head_d, tail_q, tail_d, front_q, front_d;
	logic [CW-1:0]    pos_q, pos_d;
	logic [NW-1:0]    t_q, t_d, q_q, q_d;
	logic [WW-1:0]    w_q, w_d;
	logic             first_q, first_d;
	logic [AW-1:0]    clr_q, clr_d, aw_q, aw_d;
	logic [5:0]       ebit_q, ebit_d;
	logic [7:0]       pn_q, pn_d;
	logic             pv_q, pv_d, pd_q, pd_d;
	logic             ov_q;
	logic [7:0]       on_q;
	logic             onv_q, odone_q;
	logic [WORDS-1:0] vval_q;

	logic          acc, load, vclr;
	logic [7:0]    ld_node;
	logic          ld_nv, ld_done;
	logic          adj_we;
	logic [AW-1:0] adj_wa, adj_ra;
	logic [63:0]   adj_wd, adj_rd;
	logic          vis_we;
	logic [WW-1:0] vis_wa;
	logic [63:0]   vis_wd, vis_rd, vis_eff;
	logic          walk_we;
	logic [NW-1:0] walk_wa, walk_ra;
	logic [SW-1:0] walk_wd, walk_rd;
	logic [CW-1:0] sp;
	logic [63:0]   bits;
	logic [5:0]    b;
	logic          found;
	logic [NW-1:0] qn;

	gdb_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// adjacency rows, one 64-bit word per (tail node, word) pair
	gdb_ram #(.W(64), .D(ROWS), .AW(AW)) u_adj (
		.clk (clk), .we (adj_we), .waddr (adj_wa), .wdata (adj_wd),
		.raddr (adj_ra), .rdata (adj_rd)
	);

	// visited marks, one valid bit per word
	gdb_ram #(.W(64), .D(WORDS), .AW(WW)) u_vis (
		.clk (clk), .we (vis_we), .waddr (vis_wa), .wdata (vis_wd),
		.raddr (w_q), .rdata (vis_rd)
	);

	// stack or queue entries: node and scan position
	gdb_ram #(.W(SW), .D(NODES), .AW(NW)) u_walk (
		.clk (clk), .we (walk_we), .waddr (walk_wa), .wdata (walk_wd),
		.raddr (walk_ra), .rdata (walk_rd)
	);

	assign req.ready = (st_q == S_IDLE) && (!ov_q || res.ready);
	assign acc       = req.valid && req.ready;

	// scan of one adjacency word against the visited marks
	assign vis_eff = vval_q[w_q] ? vis_rd : 64'd0;
	assign bits    = adj_rd & ~vis_eff & (first_q ? ({64{1'b1}} << 6'(pos_q)) : {64{1'b1}});
	assign found   = |bits;
	assign b       = low_bit(bits);
	assign qn      = NW'(32'(w_q) * 64 + 32'(b));
	assign sp      = order_q ? front_q : walk_rd[CW-1:0];

	// sequencer
	always_comb begin
		st_d = st_q; phase_d = phase_q; order_d = order_q;
		head_d = head_q; tail_d = tail_q; front_d = front_q; pos_d = pos_q;
		t_d = t_q; q_d = q_q; w_d = w_q; first_d = first_q;
		clr_d = clr_q; aw_d = aw_q; ebit_d = ebit_q;
		pn_d = pn_q; pv_d = pv_q; pd_d = pd_q;
		load = 1'b0; ld_node = 8'd0; ld_nv = 1'b0; ld_done = 1'b0; vclr = 1'b0;
		adj_we = 1'b0; adj_wa = clr_q; adj_wd = 64'd0;
		adj_ra = AW'(32'(t_q) * WORDS + 32'(w_q));
		vis_we = 1'b0; vis_wa = w_q; vis_wd = 64'd0;
		walk_we = 1'b0; walk_wa = '0; walk_wd = '0; walk_ra = '0;
		case (st_q)
			S_CLR: begin
				adj_we = 1'b1;
				clr_d  = clr_q + 1'b1;
				if (clr_q == AW'(ROWS - 1)) st_d = S_IDLE;
			end
			S_IDLE: begin
				if (acc) begin
					load = 1'b1;
					case (req.func)
						F_CLEAR: begin
							phase_d = PH_IDLE;
							clr_d   = '0;
							st_d    = S_CLR;
						end
						F_ADD: begin
							adj_ra = AW'(32'(req.edge_source) * WORDS + 32'(req.edge_target >> 6));
							aw_d   = adj_ra;
							ebit_d = req.edge_target[5:0];
							if (32'(req.edge_source) < NODES && 32'(req.edge_target) < NODES)
								st_d = S_AWR;
						end
						F_START: begin
							vclr    = 1'b1;
							order_d = cfg.mode;
							head_d  = '0;
							tail_d  = '0;
							front_d = '0;
							phase_d = PH_ARMED;
						end
						default: begin
							case (phase_q)
								PH_ARMED: begin
									if (32'(cfg.start) < NODES) begin
										vis_we  = 1'b1;
										vis_wa  = WW'(cfg.start >> 6);
										vis_wd  = 64'd1 << cfg.start[5:0];
										walk_we = 1'b1;
										walk_wd = {NW'(cfg.start), CW'(0)};
										tail_d  = CW'(1);
										phase_d = PH_WALK;
										ld_node = cfg.start;
										ld_nv   = 1'b1;
									end else begin
										phase_d = PH_DONE;
										ld_done = 1'b1;
									end
								end
								PH_WALK: begin
									load = 1'b0;
									st_d = S_CHK;
								end
								default: ld_done = 1'b1;
							endcase
						end
					endcase
				end
			end
			S_AWR: begin
				adj_we = 1'b1;
				adj_wa = aw_q;
				adj_wd = adj_rd | (64'd1 << ebit_q);
				st_d   = S_IDLE;
			end
			S_CHK: begin
				if (!order_q && tail_q != '0) begin
					walk_ra = NW'(tail_q - 1'b1);
					st_d    = S_WEV;
				end else if (order_q && head_q < tail_q && 32'(head_q) < NODES) begin
					walk_ra = NW'(head_q);
					st_d    = S_WEV;
				end else begin
					phase_d = PH_DONE;
					pn_d = 8'd0; pv_d = 1'b0; pd_d = 1'b1;
					st_d = S_OUT;
				end
			end
			S_WEV: begin
				t_d   = walk_rd[SW-1:CW];
				pos_d = sp;
				if (32'(sp) >= NODES) begin
					if (order_q) begin
						head_d  = head_q + 1'b1;
						front_d = '0;
					end else begin
						tail_d = tail_q - 1'b1;
					end
					st_d = S_CHK;
				end else begin
					w_d     = WW'(32'(sp) >> 6);
					first_d = 1'b1;
					st_d    = S_SRD;
				end
			end
			S_SRD: begin
				st_d = S_SEV;
			end
			S_SEV: begin
				if (found && tail_q < CW'(NODES)) begin
					vis_we  = 1'b1;
					vis_wd  = vis_eff | (64'd1 << b);
					q_d     = qn;
					pn_d    = 8'(32'(qn));
					pv_d    = 1'b1;
					pd_d    = 1'b0;
					walk_we = 1'b1;
					if (order_q) begin
						front_d = CW'(32'(qn) + 1);
						walk_wa = NW'(tail_q);
						walk_wd = {qn, CW'(0)};
						tail_d  = tail_q + 1'b1;
						st_d    = S_OUT;
					end else begin
						walk_wa = NW'(tail_q - 1'b1);
						walk_wd = {t_q, CW'(32'(qn) + 1)};
						st_d    = S_PUSH;
					end
				end else if (!found && w_q != WW'(WORDS - 1)) begin
					w_d     = w_q + 1'b1;
					first_d = 1'b0;
					st_d    = S_SRD;
				end else begin
					if (order_q) begin
						head_d  = head_q + 1'b1;
						front_d = '0;
					end else begin
						tail_d = tail_q - 1'b1;
					end
					st_d = S_CHK;
				end
			end
			S_PUSH: begin
				walk_we = 1'b1;
				walk_wa = NW'(tail_q);
				walk_wd = {q_q, CW'(0)};
				tail_d  = tail_q + 1'b1;
				st_d    = S_OUT;
			end
			S_OUT: begin
				if (!ov_q || res.ready) begin
					load    = 1'b1;
					ld_node = pn_q;
					ld_nv   = pv_q;
					ld_done = pd_q;
					st_d    = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_CLR;
			phase_q <= PH_IDLE;
			order_q <= 1'b0;
			head_q  <= '0;
			tail_q  <= '0;
			front_q <= '0;
			clr_q   <= '0;
			ov_q    <= 1'b0;
			vval_q  <= '0;
		end else begin
			st_q    <= st_d;
			phase_q <= phase_d;
			order_q <= order_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			front_q <= front_d;
			clr_q   <= clr_d;
			if (load) ov_q <= 1'b1;
			else if (res.ready) ov_q <= 1'b0;
			if (vclr) vval_q <= '0;
			else if (vis_we) vval_q[vis_wa] <= 1'b1;
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		t_q     <= t_d;
		q_q     <= q_d;
		w_q     <= w_d;
		first_q <= first_d;
		aw_q    <= aw_d;
		ebit_q  <= ebit_d;
		pn_q    <= pn_d;
		pv_q    <= pv_d;
		pd_q    <= pd_d;
		if (load) begin
			on_q    <= ld_node;
			onv_q   <= ld_nv;
			odone_q <= ld_done;
		end
	end

	assign res.valid      = ov_q;
	assign res.node       = on_q;
	assign res.node_valid = onv_q;
	assign res.done_res   = odone_q;

	// a word evaluation always follows its read issue
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_SEV |-> $past(st_q) == S_SRD)
		else $error("scan evaluated without a read");

	// stack or queue never exceeds its depth
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= CW'(NODES))
		else $error("walk tail beyond depth");

	// queue head never passes the tail during a breadth-first walk
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WALK && order_q) |-> head_q <= tail_q)
		else $error("queue head passed tail");

	// a result is never both a node and an end mark
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.node_valid && res.done_res))
		else $error("node and done both set");

endmodule

// ===== tb/tb_graph_dfs_bfs_order_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_graph_dfs_bfs_order_core
// Self-checking bench for the graph walk engine. Builds small random graphs,
// starts walks in both orders from configured nodes and checks every visited
// node against a behavioural walk predictor, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_graph_dfs_bfs_order_core;
	import gdb_pkg::*;

	typedef struct {
		logic [7:0] node;
		logic       node_valid;
		logic       done_res;
	} visit_res_t;

	typedef enum logic [1:0] {W_IDLE, W_ARMED, W_WALK, W_DONE} walk_state_t;

	// walk predictor and store of expected visits
	class walk_scoreboard;
		bit [255:0]  adj [256];
		bit [255:0]  seen;
		logic [7:0]  wnodes [256];
		int          scanpos [256];
		int          head, tail, fscan;
		walk_state_t wstate;
		bit          order, mode;
		logic [7:0]  first;
		visit_res_t  pending [$];
		int          errors, checked, visits, finished_walks;

		function new();
			foreach (adj[i]) adj[i] = '0;
			seen = '0;
			head = 0; tail = 0; fscan = 0;
			wstate = W_IDLE; order = 0; mode = 0; first = 8'd1;
			errors = 0; checked = 0; visits = 0; finished_walks = 0;
		endfunction

		function void write_reg(logic r, logic [31:0] v);
			if (r == REG_MODE) mode = v[0];
			else first = v[7:0];
		endfunction

		// lowest unvisited neighbour of t at or above from, 256 if none
		function int lowest_free(int t, int from);
			for (int i = from; i < 256; i++)
				if (adj[t][i] && !seen[i]) return i;
			return 256;
		endfunction

		function int step_walk();
			int q;
			if (wstate == W_ARMED) begin
				seen[first] = 1'b1;
				wnodes[0] = first; scanpos[0] = 0;
				head = 0; tail = 1; fscan = 0;
				wstate = W_WALK;
				return int'(first);
			end
			if (wstate != W_WALK) return 256;
			if (!order) begin
				while (tail > 0) begin
					q = lowest_free(wnodes[tail-1], scanpos[tail-1]);
					if (q < 256 && tail < 256) begin
						scanpos[tail-1] = q + 1;
						seen[q] = 1'b1;
						wnodes[tail] = 8'(q); scanpos[tail] = 0;
						tail++;
						return q;
					end
					tail--;
				end
			end else begin
				while (head < tail) begin
					q = lowest_free(wnodes[head], fscan);
					if (q < 256 && tail < 256) begin
						fscan = q + 1;
						seen[q] = 1'b1;
						wnodes[tail] = 8'(q);
						tail++;
						return q;
					end
					head++; fscan = 0;
				end
			end
			wstate = W_DONE;
			return 256;
		endfunction

		// accepted request: predict its result
		function void note_request(logic [1:0] f, logic [7:0] s, logic [7:0] d);
			visit_res_t r;
			int n;
			r = '{8'd0, 1'b0, 1'b0};
			case (f)
				F_CLEAR: begin
					foreach (adj[i]) adj[i] = '0;
					wstate = W_IDLE;
				end
				F_ADD: adj[s][d] = 1'b1;
				F_START: begin
					seen = '0; order = mode;
					head = 0; tail = 0; fscan = 0;
					wstate = W_ARMED;
				end
				default: begin
					n = step_walk();
					if (n < 256) begin
						r.node = 8'(n); r.node_valid = 1'b1;
					end else r.done_res = 1'b1;
				end
			endcase
			pending = {pending, r};
		endfunction

		function void check_result(logic [7:0] n, logic nv, logic dn);
			visit_res_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result node=%0d valid=%0b done=%0b",
					n, nv, dn);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (nv === 1'b1) visits++;
			if (dn === 1'b1) finished_walks++;
			if (n !== e.node || nv !== e.node_valid || dn !== e.done_res) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp node=%0d valid=%0b done=%0b, got node=%0d valid=%0b done=%0b",
						e.node, e.node_valid, e.done_res, n, nv, dn);
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	bit          no_gaps, no_stalls;
	int          sent;
	walk_scoreboard sb;

	gdb_req_if req_ch();
	gdb_res_if res_ch();

	graph_dfs_bfs_order_core uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall limit
	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// one request, valid left high for a back-to-back follower
	task automatic send_request(logic [1:0] f, logic [7:0] s, logic [7:0] d);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.func = f; req_ch.edge_source = s; req_ch.edge_target = d;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(f, s, d);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		req_ch.valid = 1'b0;
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (20) @(negedge clk);
	endtask

	// register write, only with the engine idle
	task automatic write_reg(logic r, logic [31:0] v);
		drain();
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = {r, 2'b00}; pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		sb.write_reg(r, v);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
	endtask

	// result side with random stalls
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_stalls ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (res_ch.valid !== 1'b1);
			sb.check_result(res_ch.node, res_ch.node_valid, res_ch.done_res);
		end
	end

	// stimulus
	initial begin
		int base, span, nedges, nfetch, walks;
		logic [7:0] a, b;
		sb = new();
		sent = 0; walks = 0;
		no_gaps = 0; no_stalls = 0;
		req_ch.valid = 1'b0; req_ch.func = F_CLEAR;
		req_ch.edge_source = '0; req_ch.edge_target = '0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle fetch, extreme edges, self loop, duplicate
		send_request(F_FETCH, 8'd0, 8'd0);
		send_request(F_ADD, 8'd1, 8'd255);
		send_request(F_ADD, 8'd255, 8'd0);
		send_request(F_ADD, 8'd255, 8'd255);
		send_request(F_ADD, 8'd1, 8'd255);
		send_request(F_ADD, 8'd0, 8'd1);
		send_request(F_ADD, 8'd1, 8'd64);
		send_request(F_START, 8'd255, 8'd255);
		repeat (3) send_request(F_FETCH, 8'hff, 8'h00);
		// edge added mid walk, then mode flipped mid walk
		send_request(F_ADD, 8'd64, 8'd128);
		write_reg(REG_MODE, 32'd1);
		repeat (4) send_request(F_FETCH, 8'h00, 8'hff);
		send_request(F_FETCH, 8'h00, 8'h00);
		// breadth-first from node 0
		write_reg(REG_START, 32'd0);
		send_request(F_START, 8'd0, 8'd0);
		repeat (6) send_request(F_FETCH, 8'd0, 8'd0);
		send_request(F_CLEAR, 8'd0, 8'd0);
		send_request(F_FETCH, 8'd0, 8'd0);

		// random walks over small node windows
		while (sent < 1000) begin
			walks++;
			no_gaps = ($urandom_range(0, 5) == 0);
			no_stalls = ($urandom_range(0, 5) == 0);
			base = $urandom_range(0, 255);
			span = $urandom_range(2, 20);
			write_reg(REG_MODE, $urandom);
			write_reg(REG_START, (walks % 9 == 0) ? 32'd255 :
				32'((base + $urandom_range(0, span - 1)) & 255));
			if ($urandom_range(0, 5) == 0)
				send_request(F_CLEAR, 8'($urandom), 8'($urandom));
			nedges = $urandom_range(span, 3 * span);
			repeat (nedges) begin
				a = 8'((base + $urandom_range(0, span - 1)) & 255);
				b = 8'((base + $urandom_range(0, span - 1)) & 255);
				if ($urandom_range(0, 15) == 0) b = 8'($urandom);
				send_request(F_ADD, a, b);
			end
			send_request(F_START, 8'($urandom), 8'($urandom));
			nfetch = span + $urandom_range(0, 3);
			repeat (nfetch) begin
				if ($urandom_range(0, 19) == 0)
					send_request($urandom_range(1, 2) == 1 ? F_ADD : F_FETCH,
						8'($urandom), 8'($urandom));
				else send_request(F_FETCH, 8'($urandom), 8'($urandom));
			end
		end

		drain();
		repeat (200) @(posedge clk);
		$display("%0d requests over %0d random walks, %0d results checked",
			sent, walks, sb.checked);
		$display("%0d visited nodes and %0d end-of-walk reports seen, %0d errors",
			sb.visits, sb.finished_walks, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/gdb_pkg.sv
rtl/gdb_ifs.sv
rtl/gdb_ram.sv
rtl/gdb_apb_regs.sv
rtl/graph_dfs_bfs_order_core.sv
tb/tb_graph_dfs_bfs_order_core.sv
